// ----- rtl/core/skt_pkg.sv -----
// skt_pkg: constants, command and status codes for the sorted key table.
// No dependencies.
`default_nettype none
package skt_pkg;
   localparam int DEPTH = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] CMD_INSERT     = 3'd0;
   localparam logic [2:0] CMD_REMOVE_KEY = 3'd1;
   localparam logic [2:0] CMD_FIND       = 3'd2;
   localparam logic [2:0] CMD_FIND_NEXT  = 3'd3;
   localparam logic [2:0] CMD_READ_IDX   = 3'd4;
   localparam logic [2:0] CMD_REMOVE_IDX = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOTFND  = 3'd1;
   localparam logic [2:0] ST_DUP     = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_REFUSED = 3'd4;

   localparam logic REG_ALLOW_DUP = 1'b0;
   localparam logic REG_UNSORTED  = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/skt_ifc.sv -----
// skt_ifc: valid/ready channel interfaces for request, response and csr.
// Depends on nothing.
`default_nettype none
interface skt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] key;
   logic [5:0]  slot_index;
   modport source (output valid, cmd, key, slot_index, input ready);
   modport sink (input valid, cmd, key, slot_index, output ready);
endinterface

interface skt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] key_out;
   logic [6:0]  entries_now;
   modport source (output valid, status, key_out, entries_now, input ready);
   modport sink (input valid, status, key_out, entries_now, output ready);
endinterface

interface skt_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/skt_ram.sv -----
// skt_ram: generic simple dual-port RAM, one write and one registered read a cycle.
// No dependencies.
`default_nettype none
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH_W = 64
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH_W)-1:0] waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic [$clog2(DEPTH_W)-1:0] raddr,
   output      logic [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem [DEPTH_W];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/sorted_key_table.sv -----
// sorted_key_table: top level, sequencer around one key RAM, a shared key comparator and a sort comparator.
// Depends on skt_pkg, skt_ifc, skt_ram.
//
//   channel | dir | beat contents
//   req     | in  | cmd, key, slot_index
//   rsp     | out | status, key_out, entries_now
//   csr     | in  | index, data (0 allow_duplicates, 1 unsorted_mode)
//
// Each step is one RAM read (with registered data) or one move.
// Binary search: probes, then a check read for an exact match; linear: walks up to count entries.
// Insert (sorted): dup search unless duplicates allowed, check read, position search, then
// entries shifted one at a time (read, then write); unsorted appends. Remove shifts the same way.
// Leaving unsorted mode runs an insertion sort before csr ready returns.
// Reset is synchronous; clears count and modes.
// req is not ready from accept until the response beat is taken, nor while csr is valid.
`default_nettype none
module sorted_key_table
   import skt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   skt_req_if.sink  req,
   skt_rsp_if.source rsp,
   skt_csr_if.sink  csr
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRCH  = 4'd1;  // issue read at probe
   localparam logic [3:0] S_SCMP  = 4'd2;  // compare read data
   localparam logic [3:0] S_DISP  = 4'd3;  // act on search result
   localparam logic [3:0] S_RDWT  = 4'd4;  // indexed read wait
   localparam logic [3:0] S_SHRD  = 4'd5;  // shift: issue read
   localparam logic [3:0] S_SHWR  = 4'd6;  // shift: write moved entry
   localparam logic [3:0] S_RESP  = 4'd7;
   localparam logic [3:0] S_SORTR = 4'd8;  // sort: read j-1
   localparam logic [3:0] S_SORTC = 4'd9;  // sort: compare/move
   localparam logic [3:0] S_SORTV = 4'd10; // sort: read v at i

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dup_ff, dup_in, uns_ff, uns_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;   // search bounds / indices
   logic [CNT_W-1:0]  pos_ff, pos_in;               // shift cursor
   logic              strict_ff, strict_in;         // bound type
   logic              phase_ff, phase_in;           // insert: dup check done
   logic [2:0]        st_ff, st_in;
   logic [KEY_WIDTH-1:0] kout_ff, kout_in;
   logic              found_ff, found_in;
   logic [KEY_WIDTH-1:0] v_ff, v_in;                // sort carry key

   logic                 we;
   logic [IDX_W-1:0]     waddr, raddr;
   logic [KEY_WIDTH-1:0] wdata, rdata;

   skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH_W(DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata));

   // shared comparator
   logic              lt_k, eq_k;
   assign lt_k = rdata < key_ff;
   assign eq_k = rdata == key_ff;

   logic [CNT_W-1:0] mid;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   logic csr_hit_uns;
   assign csr_hit_uns = csr.valid && csr.ready && (csr.index == 32'(REG_UNSORTED));

   // csr beat wins over a request beat in the same cycle
   assign req.ready = (state_ff == S_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.status = st_ff;
   assign rsp.key_out = kout_ff;
   assign rsp.entries_now = 7'(count_ff);

   always_comb begin
      state_in = state_ff; count_in = count_ff; dup_in = dup_ff; uns_in = uns_ff;
      cmd_in = cmd_ff; key_in = key_ff; lo_in = lo_ff; hi_in = hi_ff;
      pos_in = pos_ff; strict_in = strict_ff; phase_in = phase_ff;
      st_in = st_ff; kout_in = kout_ff; found_in = found_ff; v_in = v_ff;
      we = 1'b0; waddr = '0; wdata = key_ff; raddr = IDX_W'(mid);
      unique case (state_ff)
         S_IDLE: begin
            if (csr.valid) begin
               if (csr.index == 32'(REG_ALLOW_DUP)) dup_in = csr.data[0];
               if (csr_hit_uns) begin
                  uns_in = csr.data[0];
                  if (uns_ff && !csr.data[0] && count_ff > 1) begin
                     lo_in = CNT_W'(1);               // i
                     state_in = S_SORTV;
                  end
               end
            end else if (req.valid) begin
               cmd_in = req.cmd; key_in = req.key;
               st_in = ST_OK; kout_in = '0; phase_in = 1'b0; found_in = 1'b0;
               lo_in = '0; hi_in = count_ff; strict_in = 1'b0;
               unique case (req.cmd)
                  CMD_INSERT, CMD_REMOVE_KEY, CMD_FIND: begin
                     if (!(req.cmd == CMD_INSERT && dup_ff)) state_in = S_SRCH;
                     else state_in = S_DISP;
                  end
                  CMD_FIND_NEXT: begin
                     if (uns_ff) begin st_in = ST_REFUSED; state_in = S_RESP; end
                     else begin strict_in = 1'b1; state_in = S_SRCH; end
                  end
                  CMD_READ_IDX, CMD_REMOVE_IDX: begin
                     if (CNT_W'(req.slot_index) < count_ff) begin
                        lo_in = CNT_W'(req.slot_index);
                        found_in = 1'b1;
                        strict_in = 1'b1;   // read not yet issued
                        state_in = S_RDWT;
                     end else begin
                        st_in = ST_REFUSED; state_in = S_RESP;
                     end
                  end
                  CMD_CLEAR: begin count_in = '0; state_in = S_RESP; end
                  default: begin st_in = ST_REFUSED; state_in = S_RESP; end
               endcase
            end
         end
         S_SRCH: begin
            // linear: lo walks; binary: lo/hi bounds
            if (lo_ff >= hi_ff) state_in = S_DISP;
            else begin
               raddr = (uns_ff && !strict_ff) ? IDX_W'(lo_ff) : IDX_W'(mid);
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            state_in = S_SRCH;
            if (uns_ff && !strict_ff) begin
               if (eq_k) begin found_in = 1'b1; state_in = S_DISP; end
               else lo_in = lo_ff + 1'b1;
            end else if (strict_ff ? (lt_k || eq_k) : lt_k) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         S_DISP: begin
            // lo holds position; for sorted exact, verify with a read
            if (!uns_ff && !strict_ff && !found_ff && lo_ff < count_ff) begin
               raddr = IDX_W'(lo_ff);
               strict_in = 1'b1;   // mark check pending
               state_in = S_RDWT;
            end else begin
               state_in = S_RESP;
               if (cmd_ff == CMD_INSERT && !phase_ff) begin
                  if (found_ff && !dup_ff) st_in = ST_DUP;
                  else if (count_ff >= CNT_W'(DEPTH)) st_in = ST_FULL;
                  else if (!uns_ff) begin
                     phase_in = 1'b1; found_in = 1'b0; strict_in = 1'b1;
                     lo_in = '0; hi_in = count_ff; state_in = S_SRCH;
                  end else begin
                     we = 1'b1; waddr = IDX_W'(count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else if (cmd_ff == CMD_INSERT) begin
                  // open slot at lo: shift down from top
                  pos_in = count_ff; state_in = S_SHRD;
               end else if (cmd_ff == CMD_FIND_NEXT) begin
                  if (lo_ff < count_ff) begin
                     raddr = IDX_W'(lo_ff); found_in = 1'b1;
                     strict_in = 1'b0; state_in = S_RDWT;
                  end else st_in = ST_NOTFND;
               end else if (found_ff) begin
                  raddr = IDX_W'(lo_ff); state_in = S_RDWT;
               end else st_in = ST_NOTFND;
            end
         end
         S_RDWT: begin
            raddr = IDX_W'(lo_ff);
            if (!found_ff) begin
               // sorted exact check
               strict_in = 1'b0;
               found_in = eq_k;
               state_in = S_DISP;
               if (!eq_k) lo_in = count_ff;
            end else if (strict_ff) begin
               state_in = S_RDWT; strict_in = 1'b0; // read issued, wait data
            end else begin
               kout_in = rdata;
               if (cmd_ff == CMD_REMOVE_KEY || cmd_ff == CMD_REMOVE_IDX) begin
                  pos_in = lo_ff; state_in = S_SHRD;
               end else state_in = S_RESP;
            end
         end
         S_SHRD: begin
            if (cmd_ff == CMD_INSERT) begin
               if (pos_ff == lo_ff) begin
                  we = 1'b1; waddr = IDX_W'(lo_ff);
                  count_in = count_ff + 1'b1; state_in = S_RESP;
               end else begin
                  raddr = IDX_W'(pos_ff - 1'b1); state_in = S_SHWR;
               end
            end else begin
               if (pos_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1; state_in = S_RESP;
               end else begin
                  raddr = IDX_W'(pos_ff + 1'b1); state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            we = 1'b1; waddr = IDX_W'(pos_ff); wdata = rdata;
            pos_in = (cmd_ff == CMD_INSERT) ? pos_ff - 1'b1 : pos_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         S_SORTV: begin
            // insertion sort, i in lo, j in hi; read key i
            if (lo_ff >= count_ff) state_in = S_IDLE;
            else begin
               raddr = IDX_W'(lo_ff); hi_in = lo_ff; phase_in = 1'b0;
               state_in = S_SORTR;
            end
         end
         S_SORTR: begin
            if (!phase_ff) begin v_in = rdata; phase_in = 1'b1; end
            if (hi_ff == '0) begin
               we = 1'b1; waddr = '0; wdata = phase_ff ? v_ff : rdata;
               lo_in = lo_ff + 1'b1; state_in = S_SORTV;
            end else begin
               raddr = IDX_W'(hi_ff - 1'b1); state_in = S_SORTC;
            end
         end
         S_SORTC: begin
            if (rdata > v_ff) begin
               we = 1'b1; waddr = IDX_W'(hi_ff); wdata = rdata;
               hi_in = hi_ff - 1'b1; state_in = S_SORTR;
            end else begin
               we = 1'b1; waddr = IDX_W'(hi_ff); wdata = v_ff;
               lo_in = lo_ff + 1'b1; state_in = S_SORTV;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; dup_ff <= 1'b0; uns_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in;
         dup_ff <= dup_in; uns_ff <= uns_in;
      end
      cmd_ff <= cmd_in; key_ff <= key_in; lo_ff <= lo_in; hi_ff <= hi_in;
      pos_ff <= pos_in; strict_ff <= strict_in; phase_ff <= phase_in;
      st_ff <= st_in; kout_ff <= kout_in; found_ff <= found_in; v_ff <= v_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("count above depth");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.key_out))
      else $error("response dropped");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> count_ff == $past(count_ff)
         || count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1)
      else $error("count jumped");
   a_ok_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> rsp.key_out == '0)
      else $error("key on error");
endmodule
`default_nettype wire

// ----- tb/skt_tb_pkg.sv -----
// skt_tb_pkg: beat types shared by the testbench of the sorted key table.
// Depends on skt_pkg.
`timescale 1ns / 100ps
package skt_tb_pkg;
   import skt_pkg::*;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [5:0]  slot_index;
   } cmd_beat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key_out;
      logic [6:0]  entries_now;
   } reply_beat_type;
endpackage

// ----- tb/tb.sv -----
// tb: self-checking testbench for sorted_key_table with a built-in table predictor.
// Depends on skt_pkg, skt_tb_pkg, skt_ifc and the RTL.
`timescale 1ns / 100ps
module tb;
   import skt_pkg::*;
   import skt_tb_pkg::*;

   localparam int STALL_LIMIT = 200000;
   localparam logic [2:0] CMD_BAD = 3'd7;

   logic clock;
   logic reset;

   skt_req_if req ();
   skt_rsp_if rsp ();
   skt_csr_if csr ();

   sorted_key_table i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // predictor state
   logic [31:0] tbl_keys[DEPTH];
   int          tbl_count;
   bit          dup_ok;
   bit          unsorted;

   cmd_beat_type   pending_cmds[$];
   reply_beat_type expected_replies[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          errors;
   int          quiet_cycles;

   function automatic int lower_pos(logic [31:0] k, bit strict);
      int lo, hi, mid;
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (strict ? (tbl_keys[mid] <= k) : (tbl_keys[mid] < k)) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic int locate(logic [31:0] k);
      int p;
      if (unsorted) begin
         for (p = 0; p < tbl_count; p++)
            if (tbl_keys[p] == k) return p;
         return tbl_count;
      end
      p = lower_pos(k, 0);
      if (p < tbl_count && tbl_keys[p] == k) return p;
      return tbl_count;
   endfunction

   function automatic void drop_at(int p);
      for (int i = p; i < tbl_count - 1; i++) tbl_keys[i] = tbl_keys[i + 1];
      tbl_count--;
   endfunction

   function automatic void apply_csr(int idx, logic [31:0] v);
      logic [31:0] t;
      int j;
      if (idx == REG_ALLOW_DUP) dup_ok = v[0];
      else if (idx == REG_UNSORTED) begin
         if (unsorted && !v[0]) begin
            for (int i = 1; i < tbl_count; i++) begin
               t = tbl_keys[i];
               j = i;
               while (j > 0 && tbl_keys[j - 1] > t) begin
                  tbl_keys[j] = tbl_keys[j - 1];
                  j--;
               end
               tbl_keys[j] = t;
            end
         end
         unsorted = v[0];
      end
   endfunction

   function automatic reply_beat_type predict_reply(cmd_beat_type c);
      reply_beat_type r;
      int p;
      r = '0;
      case (c.cmd)
         CMD_INSERT: begin
            if (!dup_ok && locate(c.key) < tbl_count) r.status = ST_DUP;
            else if (tbl_count >= DEPTH) r.status = ST_FULL;
            else begin
               p = unsorted ? tbl_count : lower_pos(c.key, 1);
               for (int i = tbl_count; i > p; i--) tbl_keys[i] = tbl_keys[i - 1];
               tbl_keys[p] = c.key;
               tbl_count++;
            end
         end
         CMD_REMOVE_KEY: begin
            p = locate(c.key);
            if (p < tbl_count) begin
               r.key_out = tbl_keys[p];
               drop_at(p);
            end else r.status = ST_NOTFND;
         end
         CMD_FIND: begin
            p = locate(c.key);
            if (p < tbl_count) r.key_out = tbl_keys[p];
            else r.status = ST_NOTFND;
         end
         CMD_FIND_NEXT: begin
            if (unsorted) r.status = ST_REFUSED;
            else begin
               p = lower_pos(c.key, 1);
               if (p < tbl_count) r.key_out = tbl_keys[p];
               else r.status = ST_NOTFND;
            end
         end
         CMD_READ_IDX: begin
            if (c.slot_index < tbl_count) r.key_out = tbl_keys[c.slot_index];
            else r.status = ST_REFUSED;
         end
         CMD_REMOVE_IDX: begin
            if (c.slot_index < tbl_count) begin
               r.key_out = tbl_keys[c.slot_index];
               drop_at(c.slot_index);
            end else r.status = ST_REFUSED;
         end
         CMD_CLEAR: tbl_count = 0;
         default: r.status = ST_REFUSED;
      endcase
      r.entries_now = tbl_count[6:0];
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
      end else if (!req.valid || req.ready) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid <= 1;
            {req.cmd, req.key, req.slot_index} <= pending_cmds.pop_front();
         end else begin
            req.valid <= 0;
         end
      end
   end

   // response stall
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // predictor on accepted command beats, checker on accepted reply beats
   always @(posedge clock) begin
      reply_beat_type got, want;
      bit hit;
      if (!reset) begin
         hit = (req.valid && req.ready) || (csr.valid && csr.ready)
               || (rsp.valid && rsp.ready);
         quiet_cycles <= hit ? 0 : quiet_cycles + 1;
         if (req.valid && req.ready) begin
            expected_replies.push_back(predict_reply({req.cmd, req.key, req.slot_index}));
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.status, rsp.key_out, rsp.entries_now};
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply beat %h", $time, got);
               errors++;
            end else begin
               want = expected_replies.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                  errors++;
               end
               if (got.key_out !== want.key_out) begin
                  $display("%0t: key_out exp %h got %h", $time, want.key_out, got.key_out);
                  errors++;
               end
               if (got.entries_now !== want.entries_now) begin
                  $display("%0t: entries_now exp %0d got %0d", $time, want.entries_now,
                           got.entries_now);
                  errors++;
               end
            end
         end
         if (quiet_cycles > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_key(int pool);
      // narrow pool gives hits; otherwise full-range keys
      if (pool > 0 && $urandom_range(3) != 0) return $urandom_range(pool);
      return $urandom;
   endfunction

   task automatic push_cmd(logic [2:0] c, logic [31:0] k, logic [5:0] s);
      cmd_beat_type b;
      b.cmd = c;
      b.key = k;
      b.slot_index = s;
      pending_cmds.push_back(b);
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || req.valid || expected_replies.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_csr(int idx, logic [31:0] v);
      drain();
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      apply_csr(idx, v);
      csr.valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_burst(int n, int pool);
      int w;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(99);
         if (w < 38) push_cmd(CMD_INSERT, rand_key(pool), 6'($urandom));
         else if (w < 50) push_cmd(CMD_REMOVE_KEY, rand_key(pool), 6'($urandom));
         else if (w < 62) push_cmd(CMD_FIND, rand_key(pool), 6'($urandom));
         else if (w < 74) push_cmd(CMD_FIND_NEXT, rand_key(pool), 6'($urandom));
         else if (w < 85) push_cmd(CMD_READ_IDX, $urandom, 6'($urandom));
         else if (w < 96) push_cmd(CMD_REMOVE_IDX, $urandom, 6'($urandom));
         else if (w < 98) push_cmd(CMD_CLEAR, $urandom, 6'($urandom));
         else push_cmd(CMD_BAD, $urandom, 6'($urandom));
      end
   endtask

   task automatic run_phase(int idle, int stall, int n, int pool);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      random_burst(n, pool);
      drain();
   endtask

   initial begin
      errors = 0;
      quiet_cycles = 0;
      tbl_count = 0;
      dup_ok = 0;
      unsorted = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      req.valid = 0;
      req.cmd = '0;
      req.key = '0;
      req.slot_index = '0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.index = '0;
      csr.data = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, refusals
      push_cmd(CMD_FIND_NEXT, 32'h0, 6'd0);
      push_cmd(CMD_READ_IDX, 32'h0, 6'd63);
      push_cmd(CMD_REMOVE_IDX, 32'h0, 6'd0);
      push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
      push_cmd(CMD_INSERT, 32'h0, 6'd0);
      push_cmd(CMD_INSERT, 32'h8000_0000, 6'd0);
      push_cmd(CMD_INSERT, 32'h8000_0000, 6'd0);
      push_cmd(CMD_FIND, 32'hFFFF_FFFF, 6'd0);
      push_cmd(CMD_FIND_NEXT, 32'h0, 6'd0);
      push_cmd(CMD_FIND_NEXT, 32'hFFFF_FFFF, 6'd0);
      push_cmd(CMD_READ_IDX, 32'h0, 6'd2);
      push_cmd(CMD_READ_IDX, 32'h0, 6'd3);
      push_cmd(CMD_REMOVE_KEY, 32'h1234_5678, 6'd0);
      push_cmd(CMD_REMOVE_KEY, 32'h0, 6'd0);
      push_cmd(CMD_REMOVE_IDX, 32'h0, 6'd1);
      push_cmd(CMD_BAD, 32'h5A5A_A5A5, 6'd42);
      push_cmd(CMD_CLEAR, 32'h0, 6'd0);
      drain();

      // fill to full, then duplicate and overflow
      write_csr(REG_ALLOW_DUP, 32'h1);
      for (int i = 0; i < DEPTH; i++) push_cmd(CMD_INSERT, $urandom_range(40), 6'($urandom));
      push_cmd(CMD_INSERT, 32'd7, 6'd0);
      push_cmd(CMD_READ_IDX, 32'h0, 6'd63);
      push_cmd(CMD_REMOVE_IDX, 32'h0, 6'd63);
      drain();
      write_csr(REG_ALLOW_DUP, 32'h0);
      push_cmd(CMD_INSERT, 32'd7, 6'd0);
      push_cmd(CMD_INSERT, 32'd1000, 6'd0);
      push_cmd(CMD_INSERT, 32'd1001, 6'd0);
      drain();

      // unsorted mode with a full table, then sort on leaving it
      write_csr(REG_UNSORTED, 32'h1);
      run_phase(0, 0, 150, 60);
      write_csr(REG_UNSORTED, 32'h0);
      write_csr(5, 32'hFFFF_FFFF);
      write_csr(3, 32'h1);

      run_phase(0, 0, 300, 300);
      write_csr(REG_ALLOW_DUP, 32'h1);
      run_phase(45, 0, 300, 50);
      write_csr(REG_UNSORTED, 32'h1);
      run_phase(0, 45, 300, 50);
      write_csr(REG_ALLOW_DUP, 32'h0);
      run_phase(21, 21, 250, 200);
      write_csr(REG_UNSORTED, 32'h0);
      run_phase(21, 21, 200, 0);
      write_csr(REG_ALLOW_DUP, 32'h1);
      write_csr(REG_UNSORTED, 32'h1);
      run_phase(21, 21, 150, 30);
      write_csr(REG_UNSORTED, 32'h0);
      run_phase(0, 0, 200, 100);

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ----- sorted_key_table.f -----
rtl/core/skt_pkg.sv
rtl/core/skt_ifc.sv
rtl/core/skt_ram.sv
rtl/core/sorted_key_table.sv
tb/skt_tb_pkg.sv
tb/tb.sv
